// File: hdl/wlf_pkg.sv
// ----------------------------------------------------------------------------
// wlf_pkg
// Types and constants shared by the word length filter modules.
// ----------------------------------------------------------------------------
package wlf_pkg;

    localparam int MAX_DROP_LEN = 32;
    localparam int CNT_W        = $clog2(MAX_DROP_LEN + 1);
    localparam int CFG_W        = 6;
    localparam int BYTE_W       = 8;

    localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'd32;
    localparam logic [BYTE_W-1:0] BLANK_LO   = 8'd9;
    localparam logic [BYTE_W-1:0] BLANK_HI   = 8'd13;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEP,
        ST_BYTES,
        ST_TAIL
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

endpackage

// File: hdl/wlf_cell.sv
// ----------------------------------------------------------------------------
// wlf_cell
// One byte slot of the word buffer: load from the input or take the neighbour.
// ----------------------------------------------------------------------------
module wlf_cell (
    input  logic                        clk,
    input  wlf_pkg::cell_ctl_t          ctl,
    input  logic [wlf_pkg::BYTE_W-1:0]  load_byte,
    input  logic [wlf_pkg::BYTE_W-1:0]  next_byte,
    output logic [wlf_pkg::BYTE_W-1:0]  byte_q
);

    logic [wlf_pkg::BYTE_W-1:0] data_reg;
    logic [wlf_pkg::BYTE_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.load)
        begin
            data_next = load_byte;
        end
        else if (ctl.shift)
        begin
            data_next = next_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign byte_q = data_reg;

endmodule

// File: hdl/wlf_chain.sv
// ----------------------------------------------------------------------------
// wlf_chain
// Row of byte cells holding the current word; shifts towards the head.
// ----------------------------------------------------------------------------
module wlf_chain (
    input  logic                        clk,
    input  logic                        store_en,
    input  logic                        shift_en,
    input  logic [wlf_pkg::CNT_W-1:0]   wr_index,
    input  logic [wlf_pkg::BYTE_W-1:0]  wr_byte,
    output logic [wlf_pkg::BYTE_W-1:0]  head_byte
);

    logic [wlf_pkg::BYTE_W-1:0] cell_q [wlf_pkg::MAX_DROP_LEN];

    genvar i;
    generate
        for (i = 0; i < wlf_pkg::MAX_DROP_LEN; i++)
        begin : g_cell
            wlf_pkg::cell_ctl_t        ctl;
            logic [wlf_pkg::BYTE_W-1:0] neighbour;

            assign ctl = '{load:  store_en && (wr_index == wlf_pkg::CNT_W'(i)),
                           shift: shift_en};

            if (i == wlf_pkg::MAX_DROP_LEN - 1)
            begin : g_tail
                assign neighbour = cell_q[i];
            end
            else
            begin : g_mid
                assign neighbour = cell_q[i+1];
            end

            wlf_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .load_byte (wr_byte),
                .next_byte (neighbour),
                .byte_q    (cell_q[i])
            );
        end
    endgenerate

    assign head_byte = cell_q[0];

endmodule

// File: hdl/word_length_filter.sv
// ----------------------------------------------------------------------------
// word_length_filter
// Drop every word of the configured length (1..32) from a byte stream.
// ----------------------------------------------------------------------------
// channel  | direction | tdata              | tuser       | tlast
// s_axis   | in        | [7:0] in_byte      | -           | end_of_input
// m_axis   | out       | [7:0] out_byte     | string_done | last_of_run
// cfg      | in        | [5:0] drop_length  | -           | -
//
// A byte that causes no result (buffered byte, dropped word) keeps the FSM in
// ST_IDLE. Results leave through the output states; the buffer flush runs at
// one byte a cycle unless m_axis stalls, out of the head of the cell row.
// Reset clears all control state; no clearing pass is needed.
// A stalled m_axis holds the flush; s_axis may be taken while the last
// result still waits in the output register.
// ----------------------------------------------------------------------------
module word_length_filter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] in_byte
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // [7:0] out_byte
    output logic                        m_axis_tuser,   // [0] string_done
    output logic                        m_axis_tlast,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [wlf_pkg::CFG_W-1:0]   cfg_data        // [5:0] drop_length
);

    wlf_pkg::state_t                state_reg, state_next;
    logic [wlf_pkg::CNT_W-1:0]      count_reg, count_next;
    logic                           first_reg, first_next;
    logic                           pass_reg, pass_next;
    logic [wlf_pkg::CFG_W-1:0]      drop_reg;
    logic                           tail_valid_reg, tail_valid_next;
    logic [wlf_pkg::BYTE_W-1:0]     tail_byte_reg, tail_byte_next;
    logic                           tail_done_reg, tail_done_next;
    logic                           ovalid_reg, ovalid_next;
    logic [wlf_pkg::BYTE_W-1:0]     obyte_reg, obyte_next;
    logic                           odone_reg, odone_next;
    logic                           olast_reg, olast_next;

    logic [wlf_pkg::CFG_W-1:0]      limit;
    logic                           accept;
    logic                           blank;
    logic                           slot_free;
    logic                           store_en;
    logic                           shift_en;
    logic                           flush;
    logic                           end_flush;
    logic [wlf_pkg::BYTE_W-1:0]     head_byte;

    assign limit = (drop_reg > wlf_pkg::CFG_W'(wlf_pkg::MAX_DROP_LEN)) ? '0 : drop_reg;
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign blank     = (s_axis_tdata == wlf_pkg::SPACE_CHAR) ||
                       ((s_axis_tdata >= wlf_pkg::BLANK_LO) &&
                        (s_axis_tdata <= wlf_pkg::BLANK_HI));
    assign slot_free = !ovalid_reg || m_axis_tready;
    assign end_flush = !pass_reg && (count_reg != '0) &&
                       (wlf_pkg::CFG_W'(count_reg) != limit);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        first_next      = first_reg;
        pass_next       = pass_reg;
        tail_valid_next = tail_valid_reg;
        tail_byte_next  = tail_byte_reg;
        tail_done_next  = tail_done_reg;
        ovalid_next     = ovalid_reg && !m_axis_tready;
        obyte_next      = obyte_reg;
        odone_next      = odone_reg;
        olast_next      = olast_reg;
        store_en        = 1'b0;
        shift_en        = 1'b0;
        flush           = 1'b0;
        s_axis_tready   = 1'b0;

        unique case (state_reg)
            wlf_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (accept)
                begin
                    tail_valid_next = 1'b0;
                    tail_byte_next  = s_axis_tdata;
                    tail_done_next  = 1'b0;
                    if (s_axis_tlast)
                    begin
                        flush           = end_flush;
                        count_next      = end_flush ? count_reg : '0;
                        pass_next       = 1'b0;
                        tail_valid_next = 1'b1;
                        tail_byte_next  = '0;
                        tail_done_next  = 1'b1;
                    end
                    else if (blank)
                    begin
                        flush      = end_flush;
                        count_next = end_flush ? count_reg : '0;
                        pass_next  = 1'b0;
                    end
                    else if (pass_reg)
                    begin
                        tail_valid_next = 1'b1;
                    end
                    else if ((wlf_pkg::CFG_W'(count_reg) < limit) &&
                             (count_reg < wlf_pkg::CNT_W'(wlf_pkg::MAX_DROP_LEN)))
                    begin
                        store_en   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        flush           = 1'b1;
                        pass_next       = 1'b1;
                        tail_valid_next = 1'b1;
                    end

                    if (s_axis_tlast)
                    begin
                        first_next = 1'b1;
                    end
                    else if (flush)
                    begin
                        first_next = 1'b0;
                    end

                    if (flush && !first_reg)
                    begin
                        state_next = wlf_pkg::ST_SEP;
                    end
                    else if (flush && (count_next != '0))
                    begin
                        state_next = wlf_pkg::ST_BYTES;
                    end
                    else if (tail_valid_next)
                    begin
                        state_next = wlf_pkg::ST_TAIL;
                    end
                end
            end

            wlf_pkg::ST_SEP:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = wlf_pkg::SPACE_CHAR;
                    odone_next  = 1'b0;
                    olast_next  = 1'b0;
                    state_next  = (count_reg != '0) ? wlf_pkg::ST_BYTES : wlf_pkg::ST_TAIL;
                end
            end

            wlf_pkg::ST_BYTES:
            begin
                if (slot_free)
                begin
                    shift_en    = 1'b1;
                    ovalid_next = 1'b1;
                    obyte_next  = head_byte;
                    odone_next  = 1'b0;
                    olast_next  = (count_reg == wlf_pkg::CNT_W'(1)) && !tail_valid_reg;
                    count_next  = count_reg - 1'b1;
                    if (count_reg == wlf_pkg::CNT_W'(1))
                    begin
                        state_next = tail_valid_reg ? wlf_pkg::ST_TAIL : wlf_pkg::ST_IDLE;
                    end
                end
            end

            wlf_pkg::ST_TAIL:
            begin
                if (slot_free)
                begin
                    ovalid_next     = 1'b1;
                    obyte_next      = tail_byte_reg;
                    odone_next      = tail_done_reg;
                    olast_next      = 1'b1;
                    tail_valid_next = 1'b0;
                    state_next      = wlf_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = wlf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= wlf_pkg::ST_IDLE;
            count_reg      <= '0;
            first_reg      <= 1'b1;
            pass_reg       <= 1'b0;
            drop_reg       <= '0;
            tail_valid_reg <= 1'b0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            first_reg      <= first_next;
            pass_reg       <= pass_next;
            tail_valid_reg <= tail_valid_next;
            ovalid_reg     <= ovalid_next;
            if (cfg_valid && cfg_ready)
            begin
                drop_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tail_byte_reg <= tail_byte_next;
        tail_done_reg <= tail_done_next;
        obyte_reg     <= obyte_next;
        odone_reg     <= odone_next;
        olast_reg     <= olast_next;
    end

    wlf_chain u_chain (
        .clk       (clk),
        .store_en  (store_en),
        .shift_en  (shift_en),
        .wr_index  (count_reg),
        .wr_byte   (s_axis_tdata),
        .head_byte (head_byte)
    );

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = obyte_reg;
    assign m_axis_tuser  = odone_reg;
    assign m_axis_tlast  = olast_reg;

endmodule

// File: hdl/wlf_checker.sv
// ----------------------------------------------------------------------------
// wlf_checker
// Port-level checks for the word length filter, bound to the top level.
// ----------------------------------------------------------------------------
module wlf_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic       s_axis_tlast,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    input  logic       m_axis_tuser,
    input  logic       m_axis_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    a_done_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == 8'd0) && m_axis_tlast)
        else $error("terminating word is not a final zero");

    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("end of string taken without emitting the terminator");

endmodule

bind word_length_filter wlf_checker u_wlf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: sim/wlf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlf_scoreboard
// Watches the stream and configuration channels of the word length filter.
// Keeps its own copy of the filter state and, for every input word accepted,
// queues the output words that the filter has to produce. Every output word
// accepted is compared field by field with the oldest one queued.
// ----------------------------------------------------------------------------
module wlf_scoreboard
    import wlf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] in_byte
    input  logic              s_axis_tlast,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [7:0]        m_axis_tdata,   // [7:0] out_byte
    input  logic              m_axis_tuser,   // [0] string_done
    input  logic              m_axis_tlast,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data,       // [5:0] drop_length
    output int                fail_count,
    output int                pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              string_done;
        logic              last_of_run;
    } out_word_t;

    out_word_t         expected_out[$];
    out_word_t         step_out[$];
    out_word_t         oldest;
    logic [BYTE_W-1:0] token_store [MAX_DROP_LEN];
    logic [CNT_W-1:0]  held_count;
    logic              first_pending;
    logic              streaming;
    logic [CFG_W-1:0]  drop_len;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic bit is_blank(logic [BYTE_W-1:0] c);
        return c == SPACE_CHAR || (c >= BLANK_LO && c <= BLANK_HI);
    endfunction

    // lengths the store cannot hold remove nothing
    function automatic int drop_limit();
        return (drop_len > MAX_DROP_LEN) ? 0 : int'(drop_len);
    endfunction

    function automatic void emit(logic [BYTE_W-1:0] b, logic done);
        step_out.push_back('{out_byte: b, string_done: done, last_of_run: 1'b0});
    endfunction

    function automatic void flush_held();
        if (!first_pending)
            emit(SPACE_CHAR, 1'b0);
        for (int i = 0; i < int'(held_count); i++)
            emit(token_store[i], 1'b0);
        first_pending = 1'b0;
        held_count    = '0;
    endfunction

    function automatic void close_token();
        if (streaming)
            streaming = 1'b0;
        else if (held_count != 0 && int'(held_count) != drop_limit())
            flush_held();
        held_count = '0;
    endfunction

    function automatic void predict_filter(logic [BYTE_W-1:0] c, logic fin);
        step_out.delete();
        if (fin)
        begin
            close_token();
            emit('0, 1'b1);
            held_count    = '0;
            first_pending = 1'b1;
            streaming     = 1'b0;
        end
        else if (is_blank(c))
            close_token();
        else if (streaming)
            emit(c, 1'b0);
        else if (int'(held_count) < drop_limit() && int'(held_count) < MAX_DROP_LEN)
        begin
            token_store[held_count] = c;
            held_count++;
        end
        else
        begin
            flush_held();
            emit(c, 1'b0);
            streaming = 1'b1;
        end
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last_of_run = 1'b1;
        foreach (step_out[i])
            expected_out.push_back(step_out[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count    = '0;
            first_pending = 1'b1;
            streaming     = 1'b0;
            drop_len      = '0;
            expected_out.delete();
            pending <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_filter(s_axis_tdata, s_axis_tlast);
            if (cfg_valid && cfg_ready)
                drop_len = cfg_data;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_out.size() == 0)
                begin
                    $error("unexpected output word: out_byte %02h string_done %0b last_of_run %0b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    oldest = expected_out.pop_front();
                    if (m_axis_tdata !== oldest.out_byte ||
                        m_axis_tuser !== oldest.string_done ||
                        m_axis_tlast !== oldest.last_of_run)
                        fail_count <= fail_count + 1;
                    if (m_axis_tdata !== oldest.out_byte)
                        $error("out_byte: expected %02h, got %02h",
                               oldest.out_byte, m_axis_tdata);
                    if (m_axis_tuser !== oldest.string_done)
                        $error("string_done: expected %0b, got %0b",
                               oldest.string_done, m_axis_tuser);
                    if (m_axis_tlast !== oldest.last_of_run)
                        $error("last_of_run: expected %0b, got %0b",
                               oldest.last_of_run, m_axis_tlast);
                end
            end
            pending <= expected_out.size();
        end
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the word length filter.
// Directed strings cover empty and blank-only strings, byte zero, every
// blank byte, dropped, kept and streamed words, and drop lengths changed
// inside a word, plus one long output hold-off. Random strings then run
// under a range of drop lengths, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb;

    import wlf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 40;
    localparam int LONG_HOLD   = 300;
    localparam int TOTAL_ITEMS = 300;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_SPARSE,
        RX_ROTATE
    } rx_mode_t;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata  = '0;
    logic             s_axis_tlast  = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [7:0]       m_axis_tdata;
    logic             m_axis_tuser;
    logic             m_axis_tlast;
    logic             cfg_valid     = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data      = '0;

    int fail_count;
    int pending;
    int cycles        = 0;
    int burst_left    = 0;
    int items_sent    = 0;
    int hold_requests = 0;

    word_length_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    wlf_scoreboard u_scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("word_length_filter test failed");
            $finish;
        end
    end

    // output side: stall pattern of its own, long hold-off on request
    initial
    begin : receiver
        rx_mode_t    mode;
        int          mode_left;
        int          hold_left;
        int          hold_served;
        logic [31:0] mask;
        mode        = RX_STEADY;
        mode_left   = 0;
        hold_left   = 0;
        hold_served = 0;
        mask        = '0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && hold_served != hold_requests)
            begin
                hold_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 120);
                    mask      = $urandom;
                end
                mode_left--;
                case (mode)
                    RX_STEADY: m_axis_tready <= 1'b1;
                    RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 4) != 0);
                    default:
                    begin
                        mask = {mask[30:0], mask[31]};
                        m_axis_tready <= mask[0];
                    end
                endcase
            end
        end
    end

    function automatic logic [7:0] rand_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == SPACE_CHAR || (c >= BLANK_LO && c <= BLANK_HI));
        return c;
    endfunction

    function automatic logic [7:0] rand_blank();
        int pick;
        pick = $urandom_range(0, 6);
        return (pick == 6) ? SPACE_CHAR : BLANK_LO + pick[7:0] % 5;
    endfunction

    // hold each word until taken; gaps fall between bursts
    task automatic offer_char(input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
        items_sent++;
    endtask

    task automatic offer_text(input string s);
        for (int i = 0; i < s.len(); i++)
            offer_char(s[i], 1'b0);
    endtask

    task automatic end_string();
        offer_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic offer_token(input int len);
        for (int i = 0; i < len; i++)
            offer_char(rand_char(), 1'b0);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_drop_length(input logic [CFG_W-1:0] v);
        drain();
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // tokens near the drop length, blank runs between, some raw noise
    task automatic random_string(input int lim);
        int ntok;
        int len;
        ntok = $urandom_range(1, (lim > 8) ? 2 : 4);
        if ($urandom_range(0, 3) == 0)
            offer_char(rand_blank(), 1'b0);
        for (int t = 0; t < ntok; t++)
        begin
            case ($urandom_range(0, 3))
                0:       len = lim - 1;
                1:       len = lim;
                2:       len = lim + 1;
                default: len = $urandom_range(1, 8);
            endcase
            if (len < 1)
                len = $urandom_range(1, 4);
            if (len > 40)
                len = $urandom_range(1, 40);
            offer_token(len);
            if ($urandom_range(0, 9) == 0)
                offer_char(8'($urandom_range(0, 255)), 1'b0);
            if (t < ntok - 1 || $urandom_range(0, 7) != 0)
                repeat ($urandom_range(1, 3)) offer_char(rand_blank(), 1'b0);
        end
        end_string();
    endtask

    initial
    begin : stimulus
        logic [CFG_W-1:0] lengths [10];
        int               lim;
        lengths = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd5, 6'd8, 6'd31, 6'd32, 6'd33, 6'd63};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_drop_length(6'd3);
        end_string();
        offer_char(SPACE_CHAR, 1'b0);
        offer_char(8'd9, 1'b0);
        offer_char(8'd13, 1'b0);
        end_string();
        offer_text("a");
        offer_char(8'h00, 1'b0);
        offer_text("b");
        offer_char(8'd10, 1'b0);
        offer_text("cd");
        offer_char(8'd12, 1'b0);
        offer_char(8'hff, 1'b0);
        offer_char(8'h80, 1'b0);
        offer_char(8'h7f, 1'b0);
        offer_char(8'h01, 1'b0);
        offer_char(8'd11, 1'b0);
        end_string();

        // shrink the limit under a held token: flush on the next byte
        set_drop_length(6'd5);
        offer_text("abc");
        set_drop_length(6'd2);
        offer_text("d efg");
        // held token ends at exactly the new limit: dropped
        set_drop_length(6'd5);
        offer_text(" xyz");
        set_drop_length(6'd3);
        offer_char(8'd9, 1'b0);
        end_string();

        // long output hold-off while the input keeps offering
        set_drop_length(6'd0);
        hold_requests++;
        for (int k = 0; k < 12; k++)
        begin
            offer_token(5);
            offer_char(SPACE_CHAR, 1'b0);
        end
        end_string();

        while (items_sent < TOTAL_ITEMS)
        begin
            foreach (lengths[i])
            begin
                set_drop_length(lengths[i]);
                lim = (lengths[i] > MAX_DROP_LEN) ? 0 : int'(lengths[i]);
                random_string(lim);
            end
            set_drop_length(CFG_W'($urandom_range(0, 63)));
            random_string($urandom_range(0, 10));
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("word_length_filter test passed");
        else
            $display("word_length_filter test failed");
        $finish;
    end

endmodule
